// File: hw/rtl/cope_pkg.sv
// ---------------------------------------------------------------------------
// cope_pkg - circle outline pixel generator shared types
// Register indexes, and the status group passed from the square-root unit
// back to the sequencer.
// ---------------------------------------------------------------------------
package cope_pkg;

  // register index, byte address divided by four
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_COLOR    = 2'd3
  } cope_reg_t;

  typedef struct packed {
    logic busy;   // unit iterating
    logic done;   // result valid this cycle
    logic exact;  // remainder is zero, root is exact
  } cope_root_sts_t;

endpackage

// File: hw/rtl/cope_root.sv
// ---------------------------------------------------------------------------
// cope_root - iterative integer square root
// Shift-subtract root of a 2W-bit value, one root bit per cycle.
// ---------------------------------------------------------------------------
module cope_root import cope_pkg::*; #(
  parameter int W = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2*W-1:0]       q,
  output logic [W-1:0]         root,
  output cope_root_sts_t       sts
);

  localparam int CW = $clog2(W);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [2*W-1:0]  q_r;
  logic [W+1:0]    rem_r;
  logic [W-1:0]    root_r;

  logic [W+1:0]    rem_sh;
  logic [W+1:0]    trial;
  logic            ge;
  logic [W+1:0]    rem_nxt;
  logic [W-1:0]    root_nxt;

  // bring down the next two radicand bits and try the next root bit
  assign rem_sh   = {rem_r[W-1:0], q_r[2*W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign ge       = (rem_sh >= trial);
  assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_r[W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
        q_r    <= q;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        q_r    <= {q_r[2*W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root      = root_r;
  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign sts.exact = (rem_r == '0);

endmodule

// File: hw/rtl/circle_outline_pixel_generator.sv
// ---------------------------------------------------------------------------
// circle_outline_pixel_generator - circle outline pixel writes
// Each input transfer makes one outline step and, unless finished, yields two
// pixel writes; a column pass then a row pass walk the offset from -r to r-1.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid / in_stall       in_restart
//  out      output     out_valid / out_stall     out_pixel_x, out_pixel_y,
//                                                out_pixel_value, out_last
//  cfg      input      psel/penable/pwrite       paddr, pwdata, prdata
//
//  A step that draws uses the single shared multiplier twice and then the
//  bit-serial root unit (one root bit per cycle) before its first pixel. A
//  step that draws nothing leaves the sequencer idle.
//  The input is stalled until both pixels are taken.
//  Reset is synchronous, active low; registers read back as zero after reset.
// ---------------------------------------------------------------------------
module circle_outline_pixel_generator import cope_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS+1:0] out_pixel_x,
  output logic signed [COORD_BITS+1:0] out_pixel_y,
  output logic [COLOR_BITS-1:0]        out_pixel_value,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int C  = COORD_BITS;
  localparam int PW = COORD_BITS + 2;
  localparam int DW = COORD_BITS + 1;
  localparam int RW = COORD_BITS - 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_R, ST_MUL_D, ST_DIFF, ST_START, ST_WAIT, ST_FIN, ST_OUT0, ST_OUT1
  } state_t;

  state_t state_r;

  logic [C-1:0]          cx_r, cy_r;
  logic [RW-1:0]         rad_r;
  logic [COLOR_BITS-1:0] color_r;

  logic                  rows_r;
  logic signed [DW-1:0]  off_r;
  logic                  fin_r;

  logic [2*C-1:0]        rr_r, dd_r, q_r;

  logic                  out_valid_r, out_last_r, p1_last_r;
  logic signed [PW-1:0]  out_x_r, out_y_r, p1_x_r, p1_y_r;
  logic [COLOR_BITS-1:0] out_val_r;

  logic                  in_xfer, out_xfer, cfg_wr;
  logic                  fin_eff, rows_eff;
  logic signed [DW-1:0]  off_eff, neg_rad, off_neg, rad_m1;
  logic [C-1:0]          abs_d, mul_a;
  logic [2*C-1:0]        mul_p;

  logic                  root_start;
  logic [C-1:0]          root_val;
  cope_root_sts_t        root_sts;

  logic [C:0]            ceil_s;
  logic [C-1:0]          hi_c;
  logic signed [PW-1:0]  hi_s, lo_ceil, lo_floor, lo_c;
  logic signed [PW-1:0]  off_w, cx_d, cy_d, cx_s, cy_s;
  logic                  end_pass;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_CENTER_X: prdata = 32'(cx_r);
      REG_CENTER_Y: prdata = 32'(cy_r);
      REG_RADIUS:   prdata = 32'(rad_r);
      REG_COLOR:    prdata = 32'(color_r);
      default:      prdata = '0;
    endcase
  end

  // restart rewinds before the step is taken
  assign neg_rad  = -$signed({2'b00, rad_r});
  assign fin_eff  = in_restart ? (rad_r == '0) : fin_r;
  assign off_eff  = in_restart ? neg_rad : off_r;
  assign rows_eff = in_restart ? 1'b0 : rows_r;

  // one multiplier squares the radius, then the offset magnitude
  assign off_neg = -off_r;
  assign abs_d   = off_r[DW-1] ? off_neg[C-1:0] : off_r[C-1:0];
  assign mul_a   = (state_r == ST_MUL_R) ? {1'b0, rad_r} : abs_d;
  assign mul_p   = mul_a * mul_a;

  assign root_start = (state_r == ST_START);

  cope_root #(.W(C)) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .q     (q_r),
    .root  (root_val),
    .sts   (root_sts)
  );

  // pixel coordinates for this step
  assign ceil_s   = {1'b0, root_val} + (C+1)'(!root_sts.exact);
  assign hi_c     = rows_r ? cx_r : cy_r;
  assign hi_s     = $signed({2'b00, hi_c});
  assign lo_ceil  = hi_s - $signed({1'b0, ceil_s});
  assign lo_floor = hi_s - $signed({2'b00, root_val});
  assign lo_c     = lo_ceil[PW-1] ? lo_floor : lo_ceil;
  assign off_w    = {off_r[DW-1], off_r};
  assign cx_d     = $signed({2'b00, cx_r}) + off_w;
  assign cy_d     = $signed({2'b00, cy_r}) + off_w;
  assign cx_s     = $signed({2'b00, cx_r}) + $signed({2'b00, root_val});
  assign cy_s     = $signed({2'b00, cy_r}) + $signed({2'b00, root_val});
  assign rad_m1   = $signed({2'b00, rad_r}) - DW'(1);
  assign end_pass = (off_r >= rad_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cx_r        <= '0;
      cy_r        <= '0;
      rad_r       <= '0;
      color_r     <= '0;
      rows_r      <= 1'b0;
      off_r       <= '0;
      fin_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_CENTER_X: cx_r    <= pwdata[C-1:0];
          REG_CENTER_Y: cy_r    <= pwdata[C-1:0];
          REG_RADIUS:   rad_r   <= pwdata[RW-1:0];
          REG_COLOR:    color_r <= pwdata[COLOR_BITS-1:0];
          default:      ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            rows_r <= rows_eff;
            off_r  <= off_eff;
            fin_r  <= fin_eff || (rad_r == '0);
            if (!fin_eff && (rad_r != '0)) state_r <= ST_MUL_R;
          end
        end
        ST_MUL_R: begin
          rr_r    <= mul_p;
          state_r <= ST_MUL_D;
        end
        ST_MUL_D: begin
          dd_r    <= mul_p;
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          // saturate at zero when the offset lies outside the radius
          q_r     <= (dd_r > rr_r) ? '0 : (rr_r - dd_r);
          state_r <= ST_START;
        end
        ST_START: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (root_sts.done) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!rows_r) begin
            out_x_r <= cx_d;
            out_y_r <= cy_s;
            p1_x_r  <= cx_d;
            p1_y_r  <= lo_c;
          end else begin
            out_x_r <= cx_s;
            out_y_r <= cy_d;
            p1_x_r  <= lo_c;
            p1_y_r  <= cy_d;
          end
          out_val_r   <= color_r;
          out_last_r  <= 1'b0;
          p1_last_r   <= rows_r && end_pass;
          out_valid_r <= 1'b1;
          if (end_pass) begin
            if (rows_r) begin
              fin_r <= 1'b1;
            end else begin
              rows_r <= 1'b1;
              off_r  <= neg_rad;
            end
          end else begin
            off_r <= off_r + DW'(1);
          end
          state_r <= ST_OUT0;
        end
        ST_OUT0: begin
          // advance to the second pixel once the first transfer completes
          if (out_xfer) begin
            out_x_r    <= p1_x_r;
            out_y_r    <= p1_y_r;
            out_last_r <= p1_last_r;
            state_r    <= ST_OUT1;
          end
        end
        ST_OUT1: begin
          if (out_xfer) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_value = out_val_r;
  assign out_last        = out_last_r;

`ifndef NO_ASSERTIONS
  a_ready_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input ready while a pixel is pending");

  a_root_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_sts.done |-> (state_r == ST_WAIT))
    else $error("root result outside wait state");

  a_last_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (state_r == ST_OUT1))
    else $error("last flag on first pixel of a step");

  a_ready_after_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUT1) && out_xfer) |=> !in_stall)
    else $error("input not ready after second pixel transfer");
`endif

endmodule
